>>> hw/rtl/piecewise_linear_table_eval_top_defines.svh
// Assertion macros for the piecewise-linear table evaluator.
`ifndef PIECEWISE_LINEAR_TABLE_EVAL_TOP_DEFINES_SVH
`define PIECEWISE_LINEAR_TABLE_EVAL_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define PLTE_ASSERT_RST(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("plte assertion failed");
`define PLTE_ASSERT_TOP(lbl, prop) `PLTE_ASSERT_RST(lbl, i_clk, i_rst_n, prop)
`else
`define PLTE_ASSERT_RST(lbl, clk, rstn, prop)
`define PLTE_ASSERT_TOP(lbl, prop)
`endif
`endif

>>> hw/rtl/plte_pkg.sv
// Types and constants shared by the table evaluator modules.
`default_nettype none
package plte_pkg;

    localparam int DW        = 32;
    localparam int IDXW      = 7;
    localparam int CMDW      = 2;
    localparam int STW       = 2;
    localparam int CFG_IDXW  = 3;
    localparam int MAGW      = 33;
    localparam int PRODW     = 66;
    localparam int QW        = 35;
    localparam int CNTW      = 7;
    localparam int MUL_STEPS = 33;
    localparam int DIV_STEPS = 66;

    localparam logic [CMDW-1:0] CMD_WRITE = 2'd0;
    localparam logic [CMDW-1:0] CMD_EVAL  = 2'd1;
    localparam logic [CMDW-1:0] CMD_INDEX = 2'd2;

    localparam logic [STW-1:0] ST_INTERP  = 2'd0;
    localparam logic [STW-1:0] ST_DEFAULT = 2'd1;
    localparam logic [STW-1:0] ST_WRITTEN = 2'd2;
    localparam logic [STW-1:0] ST_ZERO_SP = 2'd3;

    localparam logic [CFG_IDXW-1:0] REG_DEFAULT_LOW  = 3'd0;
    localparam logic [CFG_IDXW-1:0] REG_DEFAULT_HIGH = 3'd1;
    localparam logic [CFG_IDXW-1:0] REG_NODE_COUNT   = 3'd2;
    localparam logic [CFG_IDXW-1:0] REG_UNIFORM_MODE = 3'd3;
    localparam logic [CFG_IDXW-1:0] REG_STEP_SIZE    = 3'd4;

    localparam logic [2:0] RD_LAST  = 3'd0;
    localparam logic [2:0] RD_FIRST = 3'd1;
    localparam logic [2:0] RD_SCAN  = 3'd2;
    localparam logic [2:0] RD_A     = 3'd3;
    localparam logic [2:0] RD_B     = 3'd4;

    localparam logic [2:0] RES_WRITE  = 3'd0;
    localparam logic [2:0] RES_LOW    = 3'd1;
    localparam logic [2:0] RES_HIGH   = 3'd2;
    localparam logic [2:0] RES_ZERO   = 3'd3;
    localparam logic [2:0] RES_INTERP = 3'd4;

    typedef struct packed {
        logic       load_in;
        logic       mem_wr;
        logic [2:0] rd_sel;
        logic       res_load;
        logic [2:0] res_sel;
        logic       scan_init;
        logic       scan_step;
        logic       up_given;
        logic       up_scan;
        logic       up_div;
        logic       cap_a;
        logic       cap_b;
        logic       calc;
        logic       mul_step;
        logic       div_start_uni;
        logic       div_start_int;
        logic       div_step;
        logic       out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic [CMDW-1:0] cmd;
        logic            idx_ge_n;
        logic            idx_zero;
        logic            x_ge_last;
        logic            x_lt_first;
        logic            scan_hit;
        logic            uniform;
        logic            dxs_zero;
        logic            mul_last;
        logic            div_last;
    } t_dp_sts;

endpackage
`default_nettype wire

>>> hw/rtl/piecewise_linear_table_eval_top.sv
// Piecewise-linear table evaluator: top level joining controller and datapath.
//
// One item is worked on at a time; the next is taken as soon as the previous result
// sits in the output register. A node write and a default answer skip the arithmetic.
// Interpolation runs the bit-serial multiplier and then the restoring divider, also
// for an evaluation at a given index.
// Evaluation by search first reads the last and first nodes, then either runs the
// divider once more for the bin or scans the nodes, with a read and a compare state
// per node through the single read port of the node memory. Zero spacing skips the
// multiplier and divider, and a stalled output holds the result back.
// The node tables power up undefined; read only nodes that were written.
`default_nettype none
`include "piecewise_linear_table_eval_top_defines.svh"
module piecewise_linear_table_eval_top
    import plte_pkg::*;
#(
    parameter int MAX_NODES = 64
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire logic [CMDW-1:0]     i_in_command,
    input  wire logic [IDXW-1:0]     i_in_node_index,
    input  wire logic [DW-1:0]       i_in_x_value,
    input  wire logic [DW-1:0]       i_in_y_value,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output logic [DW-1:0]            o_out_result_value,
    output logic [IDXW-1:0]          o_out_found_index,
    output logic [STW-1:0]           o_out_status,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [CFG_IDXW-1:0] i_cfg_index,
    input  wire logic [DW-1:0]       i_cfg_data
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    assign o_cfg_ready = 1'b1;

    plte_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (dp_sts),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (dp_cmd)
    );

    plte_dp #(
        .MAX_NODES (MAX_NODES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .o_sts          (dp_sts),
        .i_cfg_wr       (i_cfg_valid & o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_command      (i_in_command),
        .i_node_index   (i_in_node_index),
        .i_x_value      (i_in_x_value),
        .i_y_value      (i_in_y_value),
        .o_result_value (o_out_result_value),
        .o_found_index  (o_out_found_index),
        .o_status       (o_out_status)
    );

    `PLTE_ASSERT_TOP(a_stall_after_accept, i_in_valid && !o_in_stall |=> o_in_stall)
    `PLTE_ASSERT_TOP(a_load_when_free, dp_cmd.out_load |-> (!o_out_valid || !i_out_stall))
    `PLTE_ASSERT_TOP(a_interp_idx, o_out_valid && o_out_status == ST_INTERP |-> |o_out_found_index)

endmodule
`default_nettype wire

>>> hw/rtl/plte_ctrl.sv
// Sequencing state machine of the table evaluator.
`default_nettype none
module plte_ctrl
    import plte_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire logic    i_out_stall,
    input  wire t_dp_sts i_sts,
    output logic         o_in_stall,
    output logic         o_out_valid,
    output t_dp_cmd      o_cmd
);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_DECODE    = 4'd1;
    localparam logic [3:0] S_CHK_LAST  = 4'd2;
    localparam logic [3:0] S_CHK_FIRST = 4'd3;
    localparam logic [3:0] S_SCAN_RD   = 4'd4;
    localparam logic [3:0] S_SCAN_CMP  = 4'd5;
    localparam logic [3:0] S_DIV_U     = 4'd6;
    localparam logic [3:0] S_RDA       = 4'd7;
    localparam logic [3:0] S_RDB       = 4'd8;
    localparam logic [3:0] S_CAP_B     = 4'd9;
    localparam logic [3:0] S_CALC      = 4'd10;
    localparam logic [3:0] S_CHK_ZERO  = 4'd11;
    localparam logic [3:0] S_MUL       = 4'd12;
    localparam logic [3:0] S_DIV_I     = 4'd13;
    localparam logic [3:0] S_FIN       = 4'd14;
    localparam logic [3:0] S_DONE      = 4'd15;

    logic [3:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       out_free;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.rd_sel = RD_LAST;
                unique case (i_sts.cmd)
                    CMD_WRITE: begin
                        o_cmd.mem_wr   = 1'b1;
                        o_cmd.res_load = 1'b1;
                        o_cmd.res_sel  = RES_WRITE;
                        n_state        = S_DONE;
                    end
                    CMD_EVAL: begin
                        n_state = S_CHK_LAST;
                    end
                    CMD_INDEX: begin
                        priority if (i_sts.idx_ge_n) begin
                            o_cmd.res_load = 1'b1;
                            o_cmd.res_sel  = RES_HIGH;
                            n_state        = S_DONE;
                        end else if (i_sts.idx_zero) begin
                            o_cmd.res_load = 1'b1;
                            o_cmd.res_sel  = RES_LOW;
                            n_state        = S_DONE;
                        end else begin
                            o_cmd.up_given = 1'b1;
                            n_state        = S_RDA;
                        end
                    end
                    default: begin
                        o_cmd.res_load = 1'b1;
                        o_cmd.res_sel  = RES_LOW;
                        n_state        = S_DONE;
                    end
                endcase
            end
            S_CHK_LAST: begin
                o_cmd.rd_sel = RD_FIRST;
                if (i_sts.x_ge_last) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_sel  = RES_HIGH;
                    n_state        = S_DONE;
                end else begin
                    n_state = S_CHK_FIRST;
                end
            end
            S_CHK_FIRST: begin
                priority if (i_sts.x_lt_first) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_sel  = RES_LOW;
                    n_state        = S_DONE;
                end else if (i_sts.uniform) begin
                    o_cmd.div_start_uni = 1'b1;
                    n_state             = S_DIV_U;
                end else begin
                    o_cmd.scan_init = 1'b1;
                    n_state         = S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                o_cmd.rd_sel = RD_SCAN;
                n_state      = S_SCAN_CMP;
            end
            S_SCAN_CMP: begin
                if (i_sts.scan_hit) begin
                    o_cmd.up_scan = 1'b1;
                    n_state       = S_RDA;
                end else begin
                    o_cmd.scan_step = 1'b1;
                    n_state         = S_SCAN_RD;
                end
            end
            S_DIV_U: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_RDA;
                end
            end
            S_RDA: begin
                o_cmd.rd_sel = RD_A;
                n_state      = S_RDB;
            end
            S_RDB: begin
                o_cmd.cap_a  = 1'b1;
                o_cmd.rd_sel = RD_B;
                n_state      = S_CAP_B;
            end
            S_CAP_B: begin
                o_cmd.cap_b = 1'b1;
                n_state     = S_CALC;
            end
            S_CALC: begin
                o_cmd.calc = 1'b1;
                n_state    = S_CHK_ZERO;
            end
            S_CHK_ZERO: begin
                if (i_sts.dxs_zero) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_sel  = RES_ZERO;
                    n_state        = S_DONE;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul_step = 1'b1;
                if (i_sts.mul_last) begin
                    n_state = S_DIV_I;
                end
            end
            S_DIV_I: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.res_load = 1'b1;
                o_cmd.res_sel  = RES_INTERP;
                n_state        = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        // the divider start and the bin update ride on the last step of the unit before
        if (r_state == S_MUL && i_sts.mul_last) begin
            o_cmd.div_start_int = 1'b1;
        end
        if (r_state == S_DIV_U && i_sts.div_last) begin
            o_cmd.up_div = 1'b1;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        priority if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/plte_dp.sv
// Datapath: registers, node memory, serial multiplier and divider, result stage.
`default_nettype none
module plte_dp
    import plte_pkg::*;
#(
    parameter int MAX_NODES = 64
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_dp_cmd             i_cmd,
    output t_dp_sts                  o_sts,
    input  wire logic                i_cfg_wr,
    input  wire logic [CFG_IDXW-1:0] i_cfg_index,
    input  wire logic [DW-1:0]       i_cfg_data,
    input  wire logic [CMDW-1:0]     i_command,
    input  wire logic [IDXW-1:0]     i_node_index,
    input  wire logic [DW-1:0]       i_x_value,
    input  wire logic [DW-1:0]       i_y_value,
    output logic [DW-1:0]            o_result_value,
    output logic [IDXW-1:0]          o_found_index,
    output logic [STW-1:0]           o_status
);

    localparam int AW = $clog2(MAX_NODES);

    // configuration
    logic [DW-1:0]   r_default_low, r_default_high;
    logic [IDXW-1:0] r_node_count;
    logic            r_uniform;
    logic [DW-2:0]   r_step_size;

    // captured item
    logic [CMDW-1:0] r_in_cmd;
    logic [IDXW-1:0] r_in_idx;
    logic [DW-1:0]   r_in_x, r_in_y;

    // node memory
    logic [DW-1:0] r_node_x [MAX_NODES];
    logic [DW-1:0] r_node_y [MAX_NODES];
    logic [DW-1:0] r_rd_x, r_rd_y;
    logic [AW-1:0] rd_addr;

    logic [AW-1:0] r_idx, r_up;
    logic [DW-1:0] r_xa, r_ya, r_xb, r_yb;

    logic [MAGW-1:0]  r_a, r_d, r_rem;
    logic             r_neg, r_neg_ab, r_ab_zero, r_dxs_zero;
    logic [PRODW-1:0] r_acc;
    logic [QW-1:0]    r_q;
    logic             r_ovf;
    logic [CNTW-1:0]  r_cnt;

    logic [DW-1:0]   r_res;
    logic [IDXW-1:0] r_found;
    logic [STW-1:0]  r_stat;
    logic [DW-1:0]   r_out_res;
    logic [IDXW-1:0] r_out_found;
    logic [STW-1:0]  r_out_stat;

    logic [31:0] nc32, n32, nm1, idx32, up32;
    logic        idx_in_mem;

    always_comb begin
        nc32 = 32'(r_node_count);
        if (nc32 < 32'd2) begin
            n32 = 32'd2;
        end else if (nc32 > 32'(MAX_NODES)) begin
            n32 = 32'(MAX_NODES);
        end else begin
            n32 = nc32;
        end
    end
    assign nm1        = n32 - 32'd1;
    assign idx32      = 32'(r_in_idx);
    assign up32       = 32'(r_up);
    assign idx_in_mem = (idx32 < 32'(MAX_NODES));

    always_comb begin
        unique case (i_cmd.rd_sel)
            RD_LAST:  rd_addr = nm1[AW-1:0];
            RD_FIRST: rd_addr = '0;
            RD_SCAN:  rd_addr = r_idx;
            RD_A:     rd_addr = r_up - AW'(1);
            RD_B:     rd_addr = r_up;
            default:  rd_addr = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_wr && idx_in_mem) begin
            r_node_x[idx32[AW-1:0]] <= r_in_x;
            r_node_y[idx32[AW-1:0]] <= r_in_y;
        end
        r_rd_x <= r_node_x[rd_addr];
        r_rd_y <= r_node_y[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default_low  <= '0;
            r_default_high <= '0;
            r_node_count   <= 7'd2;
            r_uniform      <= 1'b0;
            r_step_size    <= 31'd65536;
        end else if (i_cfg_wr) begin
            unique case (i_cfg_index)
                REG_DEFAULT_LOW:  r_default_low  <= i_cfg_data;
                REG_DEFAULT_HIGH: r_default_high <= i_cfg_data;
                REG_NODE_COUNT:   r_node_count   <= i_cfg_data[IDXW-1:0];
                REG_UNIFORM_MODE: r_uniform      <= i_cfg_data[0];
                REG_STEP_SIZE:    r_step_size    <= i_cfg_data[DW-2:0];
                default: ;
            endcase
        end
    end

    // interpolation operands
    logic signed [MAGW-1:0] dy, dxq, dxs, xdiff;
    logic [MAGW-1:0]        mag_a, mag_b, mag_d;
    assign dy    = $signed({r_yb[DW-1], r_yb}) - $signed({r_ya[DW-1], r_ya});
    assign dxq   = $signed({r_in_x[DW-1], r_in_x}) - $signed({r_xa[DW-1], r_xa});
    assign dxs   = $signed({r_xb[DW-1], r_xb}) - $signed({r_xa[DW-1], r_xa});
    assign xdiff = $signed({r_in_x[DW-1], r_in_x}) - $signed({r_rd_x[DW-1], r_rd_x});
    assign mag_a = dy[MAGW-1]  ? MAGW'(-dy)  : MAGW'(dy);
    assign mag_b = dxq[MAGW-1] ? MAGW'(-dxq) : MAGW'(dxq);
    assign mag_d = dxs[MAGW-1] ? MAGW'(-dxs) : MAGW'(dxs);

    // multiplier and divider steps
    logic [MAGW:0]   mul_sum;
    logic [MAGW:0]   div_r2, div_diff;
    logic            div_ge;
    assign mul_sum  = {1'b0, r_acc[PRODW-1:MAGW]} + (r_acc[0] ? {1'b0, r_a} : '0);
    assign div_r2   = {r_rem, r_acc[PRODW-1]};
    assign div_ge   = (div_r2 >= {1'b0, r_d});
    assign div_diff = div_r2 - {1'b0, r_d};

    // quotient after the current divider step, so the bin sees the final bit
    logic [QW-1:0] q_next, q_plus1;
    logic          ovf_next;
    assign q_next   = {r_q[QW-2:0], div_ge};
    assign ovf_next = r_ovf | r_q[QW-1];
    assign q_plus1  = q_next + QW'(1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in_cmd <= i_command;
            r_in_idx <= i_node_index;
            r_in_x   <= i_x_value;
            r_in_y   <= i_y_value;
        end
        if (i_cmd.scan_init) begin
            r_idx <= '0;
        end else if (i_cmd.scan_step) begin
            r_idx <= r_idx + AW'(1);
        end
        priority if (i_cmd.up_given) begin
            r_up <= idx32[AW-1:0];
        end else if (i_cmd.up_scan) begin
            r_up <= (r_idx == '0) ? AW'(1) : r_idx;
        end else if (i_cmd.up_div) begin
            r_up <= (ovf_next || q_next >= QW'(nm1)) ? nm1[AW-1:0] : q_plus1[AW-1:0];
        end
        if (i_cmd.cap_a) begin
            r_xa <= r_rd_x;
            r_ya <= r_rd_y;
        end
        if (i_cmd.cap_b) begin
            r_xb <= r_rd_x;
            r_yb <= r_rd_y;
        end
        priority if (i_cmd.calc) begin
            r_a        <= mag_a;
            r_d        <= mag_d;
            r_neg_ab   <= dy[MAGW-1] ^ dxq[MAGW-1];
            r_neg      <= dy[MAGW-1] ^ dxq[MAGW-1] ^ dxs[MAGW-1];
            r_ab_zero  <= (mag_a == '0) || (mag_b == '0);
            r_dxs_zero <= (dxs == '0);
            r_acc      <= {{(PRODW-MAGW){1'b0}}, mag_b};
            r_cnt      <= '0;
        end else if (i_cmd.div_start_int) begin
            // the last multiply step hands the product straight to the divider
            r_acc <= {mul_sum, r_acc[MAGW-1:1]};
            r_rem <= '0;
            r_q   <= '0;
            r_ovf <= 1'b0;
            r_cnt <= '0;
        end else if (i_cmd.mul_step) begin
            r_acc <= {mul_sum, r_acc[MAGW-1:1]};
            r_cnt <= r_cnt + CNTW'(1);
        end else if (i_cmd.div_start_uni) begin
            r_acc <= {{(PRODW-MAGW){1'b0}}, MAGW'(xdiff)};
            r_d   <= (r_step_size == '0) ? MAGW'(1) : MAGW'(r_step_size);
            r_rem <= '0;
            r_q   <= '0;
            r_ovf <= 1'b0;
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_acc <= {r_acc[PRODW-2:0], 1'b0};
            r_rem <= div_ge ? div_diff[MAGW-1:0] : div_r2[MAGW-1:0];
            r_q   <= q_next;
            r_ovf <= ovf_next;
            r_cnt <= r_cnt + CNTW'(1);
        end
    end

    // interpolated value with saturation
    logic signed [QW+1:0] ya_ext, sum_ext;
    logic [DW-1:0]        sat_res, zero_res;
    logic [IDXW-1:0]      up7;
    assign ya_ext  = $signed({{(QW+2-DW){r_ya[DW-1]}}, r_ya});
    assign sum_ext = r_neg ? ya_ext - $signed({2'b00, r_q}) : ya_ext + $signed({2'b00, r_q});
    assign up7     = up32[IDXW-1:0];

    always_comb begin
        priority if (r_ovf) begin
            sat_res = r_neg ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
        end else if (sum_ext > $signed((QW+2)'(32'h7fff_ffff))) begin
            sat_res = {1'b0, {(DW-1){1'b1}}};
        end else if (sum_ext < -$signed((QW+2)'(33'h0_8000_0000))) begin
            sat_res = {1'b1, {(DW-1){1'b0}}};
        end else begin
            sat_res = sum_ext[DW-1:0];
        end
        if (r_ab_zero) begin
            zero_res = r_ya;
        end else begin
            zero_res = r_neg_ab ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            unique case (i_cmd.res_sel)
                RES_WRITE: begin
                    r_res   <= '0;
                    r_found <= r_in_idx;
                    r_stat  <= ST_WRITTEN;
                end
                RES_HIGH: begin
                    r_res   <= r_default_high;
                    r_found <= n32[IDXW-1:0];
                    r_stat  <= ST_DEFAULT;
                end
                RES_ZERO: begin
                    r_res   <= zero_res;
                    r_found <= up7;
                    r_stat  <= ST_ZERO_SP;
                end
                RES_INTERP: begin
                    r_res   <= sat_res;
                    r_found <= up7;
                    r_stat  <= ST_INTERP;
                end
                default: begin
                    r_res   <= r_default_low;
                    r_found <= '0;
                    r_stat  <= ST_DEFAULT;
                end
            endcase
        end
        if (i_cmd.out_load) begin
            r_out_res   <= r_res;
            r_out_found <= r_found;
            r_out_stat  <= r_stat;
        end
    end

    assign o_result_value = r_out_res;
    assign o_found_index  = r_out_found;
    assign o_status       = r_out_stat;

    always_comb begin
        o_sts.cmd        = r_in_cmd;
        o_sts.idx_ge_n   = (idx32 >= n32);
        o_sts.idx_zero   = (r_in_idx == '0);
        o_sts.x_ge_last  = ($signed(r_in_x) >= $signed(r_rd_x));
        o_sts.x_lt_first = ($signed(r_in_x) < $signed(r_rd_x));
        o_sts.scan_hit   = ($signed(r_in_x) <= $signed(r_rd_x)) || (32'(r_idx) == nm1);
        o_sts.uniform    = r_uniform;
        o_sts.dxs_zero   = r_dxs_zero;
        o_sts.mul_last   = (r_cnt == CNTW'(MUL_STEPS - 1));
        o_sts.div_last   = (r_cnt == CNTW'(DIV_STEPS - 1));
    end

endmodule
`default_nettype wire
